// ----- rtl/core/dbtw_pkg.sv -----
// dbtw_pkg: shared widths, codes, types and reset values of the band tuning word loader
// used by the channel interfaces, the divider, the serializer and the top level
// no dependencies
package dbtw_pkg;

  localparam int NUM_BANDS    = 3;
  localparam int WORD_BITS    = 32;
  localparam int CONTROL_BITS = 8;
  localparam int FREQ_W       = 32;
  localparam int OFFSET_W     = 8;
  localparam int CMD_W        = 3;
  localparam int SEL_W        = 2;
  localparam int BAND_W       = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam int CLOCK_HZ     = 125000000;
  localparam int CLOCK_W      = $clog2(CLOCK_HZ);
  localparam int ODD_SHIFT    = 6;
  localparam int CLOCK_ODD    = CLOCK_HZ / (2 ** ODD_SHIFT);

  // coarse quotient of freq by the clock from the top freq bits
  localparam int COARSE_SHIFT   = 20;
  localparam int COARSE_FRAC    = 16;
  localparam int COARSE_IN_W    = FREQ_W - COARSE_SHIFT;
  localparam int COARSE_RECIP_W = 10;
  localparam int COARSE_PROD_W  = COARSE_IN_W + COARSE_RECIP_W;
  localparam int COARSE_W       = FREQ_W - CLOCK_W + 1;
  localparam int REM_W          = CLOCK_W + 1;

  // word estimate from the remainder times a reciprocal of the odd clock factor
  localparam int FINE_SCALE   = WORD_BITS - ODD_SHIFT;
  localparam int FINE_FRAC    = 26;
  localparam int FINE_PROD_W  = CLOCK_W + WORD_BITS;
  localparam int RESID_W      = $clog2(2 * CLOCK_ODD);

  localparam int FRAME_EVENTS = WORD_BITS + CONTROL_BITS + 3;
  localparam int EV_W         = $clog2(FRAME_EVENTS);

  typedef logic [BAND_W-1:0]          band_t;
  typedef logic [FREQ_W-1:0]          freq_t;
  typedef logic [WORD_BITS-1:0]       word_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic [EV_W-1:0]            ev_t;
  typedef logic [COARSE_W-1:0]        coarse_t;
  typedef logic [REM_W-1:0]           rem_t;
  typedef logic [RESID_W-1:0]         resid_t;

  localparam band_t   LAST_BAND     = band_t'(NUM_BANDS - 1);
  localparam offset_t OFF_LIMIT     = offset_t'(99);
  localparam logic [COARSE_RECIP_W-1:0] COARSE_RECIP =
    COARSE_RECIP_W'((64'd1 << (COARSE_SHIFT + COARSE_FRAC)) / 64'(CLOCK_HZ));
  localparam word_t   FINE_RECIP    =
    word_t'((64'd1 << (FINE_SCALE + FINE_FRAC)) / 64'(CLOCK_ODD));
  localparam rem_t    DIVISOR_REM   = rem_t'(CLOCK_HZ);
  localparam rem_t    ODD_REM       = rem_t'(CLOCK_ODD);
  localparam resid_t  ODD_RESID     = resid_t'(CLOCK_ODD);

  localparam ev_t EV_FIRST      = ev_t'(1);
  localparam ev_t EV_LOAD       = ev_t'(1);
  localparam ev_t EV_WORD_FIRST = ev_t'(2);
  localparam ev_t EV_WORD_LAST  = ev_t'(WORD_BITS + 1);
  localparam ev_t EV_FINAL      = ev_t'(FRAME_EVENTS - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_OFFSET = 3'd0,
    CMD_NEXT_BAND  = 3'd1,
    CMD_RAISE_BASE = 3'd2,
    CMD_LOWER_BASE = 3'd3,
    CMD_SELECT     = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_EST,
    DIV_REM,
    DIV_FIX,
    DIV_MUL,
    DIV_CHECK,
    DIV_ROUND,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic  valid;
    logic  zero;
    freq_t freq;
  } div_start_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } word_req_t;

  function automatic freq_t base_reset(input int idx);
    freq_t value;
    case (idx)
      0:       value = freq_t'(10140066);
      1:       value = freq_t'(7000890);
      2:       value = freq_t'(14000830);
      default: value = '0;
    endcase
    return value;
  endfunction

endpackage

// ----- rtl/core/dbtw_if.sv -----
// dbtw_cmd_if and dbtw_pin_if: valid/ready channels for commands and pin events
// depends on dbtw_pkg for field widths
interface dbtw_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [dbtw_pkg::CMD_W-1:0]     command;
  dbtw_pkg::offset_t              offset;
  logic [dbtw_pkg::SEL_W-1:0]     band_select;

  modport source (output valid, command, offset, band_select, input ready);
  modport sink   (input valid, command, offset, band_select, output ready);
endinterface

interface dbtw_pin_if;
  logic valid;
  logic ready;
  logic pin_kind;
  logic data_bit;
  logic last;

  modport source (output valid, pin_kind, data_bit, last, input ready);
  modport sink   (input valid, pin_kind, data_bit, last, output ready);
endinterface

// ----- rtl/core/dbtw_divider.sv -----
// dbtw_divider: tuning word floor(freq * 2^32 / clock) by reciprocal products over six steps
// coarse estimate reduces freq modulo the clock, a fine product gives the word; depends on dbtw_pkg
module dbtw_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  dbtw_pkg::div_start_t start_req,
  output logic                 idle,
  output dbtw_pkg::word_req_t  word_out,
  input  logic                 word_take
);

  dbtw_pkg::div_state_t state, state_next;
  dbtw_pkg::freq_t      num, num_next;
  dbtw_pkg::coarse_t    coarse, coarse_next;
  dbtw_pkg::rem_t       rem, rem_next;
  dbtw_pkg::word_t      quo, quo_next;
  logic                 zero, zero_next;

  logic [dbtw_pkg::COARSE_PROD_W-1:0] coarse_prod;
  dbtw_pkg::rem_t                     coarse_back;
  logic [dbtw_pkg::FINE_PROD_W-1:0]   fine_prod;
  dbtw_pkg::resid_t                   resid_back;
  dbtw_pkg::resid_t                   resid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbtw_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    num    <= num_next;
    coarse <= coarse_next;
    rem    <= rem_next;
    quo    <= quo_next;
    zero   <= zero_next;
  end

  assign coarse_prod = dbtw_pkg::COARSE_PROD_W'(num[dbtw_pkg::FREQ_W-1:dbtw_pkg::COARSE_SHIFT]) *
                       dbtw_pkg::COARSE_PROD_W'(dbtw_pkg::COARSE_RECIP);
  assign coarse_back = dbtw_pkg::rem_t'(coarse) * dbtw_pkg::DIVISOR_REM;
  assign fine_prod   = dbtw_pkg::FINE_PROD_W'(rem[dbtw_pkg::CLOCK_W-1:0]) *
                       dbtw_pkg::FINE_PROD_W'(dbtw_pkg::FINE_RECIP);
  assign resid_back  = quo[dbtw_pkg::RESID_W-1:0] * dbtw_pkg::ODD_RESID;
  // low bits of remainder times 2^26 are zero
  assign resid       = dbtw_pkg::resid_t'(0) - resid_back;

  always_comb begin
    state_next  = state;
    num_next    = num;
    coarse_next = coarse;
    rem_next    = rem;
    quo_next    = quo;
    zero_next   = zero;
    unique case (state)
      dbtw_pkg::DIV_IDLE: begin
        if (start_req.valid) begin
          num_next   = start_req.freq;
          zero_next  = start_req.zero;
          state_next = dbtw_pkg::DIV_EST;
        end
      end
      dbtw_pkg::DIV_EST: begin
        coarse_next = dbtw_pkg::coarse_t'(coarse_prod >> dbtw_pkg::COARSE_FRAC);
        state_next  = dbtw_pkg::DIV_REM;
      end
      dbtw_pkg::DIV_REM: begin
        rem_next   = num[dbtw_pkg::REM_W-1:0] - coarse_back;
        state_next = dbtw_pkg::DIV_FIX;
      end
      dbtw_pkg::DIV_FIX: begin
        if (rem >= dbtw_pkg::DIVISOR_REM) begin
          rem_next = rem - dbtw_pkg::DIVISOR_REM;
        end
        state_next = dbtw_pkg::DIV_MUL;
      end
      dbtw_pkg::DIV_MUL: begin
        quo_next   = fine_prod[dbtw_pkg::FINE_FRAC+dbtw_pkg::WORD_BITS-1:dbtw_pkg::FINE_FRAC];
        state_next = dbtw_pkg::DIV_CHECK;
      end
      dbtw_pkg::DIV_CHECK: begin
        rem_next   = dbtw_pkg::rem_t'(resid);
        state_next = dbtw_pkg::DIV_ROUND;
      end
      dbtw_pkg::DIV_ROUND: begin
        if (rem >= dbtw_pkg::ODD_REM) begin
          quo_next = quo + dbtw_pkg::word_t'(1);
        end
        state_next = dbtw_pkg::DIV_DONE;
      end
      dbtw_pkg::DIV_DONE: begin
        if (word_take) begin
          state_next = dbtw_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_next = dbtw_pkg::DIV_IDLE;
      end
    endcase
  end

  assign idle           = (state == dbtw_pkg::DIV_IDLE);
  assign word_out.valid = (state == dbtw_pkg::DIV_DONE);
  assign word_out.word  = zero ? '0 : quo;

endmodule

// ----- rtl/core/dbtw_serializer.sv -----
// dbtw_serializer: turns one tuning word into the 43-event pin frame
// registered output request; depends on dbtw_pkg and dbtw_pin_if
module dbtw_serializer (
  input  logic                clk,
  input  logic                rst,
  input  dbtw_pkg::word_req_t word_in,
  output logic                word_take,
  dbtw_pin_if.source          pin
);

  logic            busy, busy_next;
  dbtw_pkg::ev_t   cnt, cnt_next;
  dbtw_pkg::word_t shreg, shreg_next;
  logic            out_valid, out_valid_next;
  logic            out_kind, out_kind_next;
  logic            out_bit, out_bit_next;
  logic            out_last, out_last_next;
  logic            advance;

  assign advance   = !out_valid || pin.ready;
  assign word_take = advance && !busy && word_in.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    shreg    <= shreg_next;
    out_kind <= out_kind_next;
    out_bit  <= out_bit_next;
    out_last <= out_last_next;
  end

  always_comb begin
    busy_next      = busy;
    cnt_next       = cnt;
    shreg_next     = shreg;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_bit_next   = out_bit;
    out_last_next  = out_last;
    if (advance) begin
      if (busy) begin
        cnt_next       = cnt + dbtw_pkg::ev_t'(1);
        out_valid_next = 1'b1;
        out_kind_next  = 1'b0;
        out_bit_next   = 1'b0;
        out_last_next  = 1'b0;
        if (cnt == dbtw_pkg::EV_LOAD) begin
          out_kind_next = 1'b1;
        end else if (cnt >= dbtw_pkg::EV_WORD_FIRST && cnt <= dbtw_pkg::EV_WORD_LAST) begin
          out_bit_next = shreg[0];
          shreg_next   = shreg >> 1;
        end else if (cnt == dbtw_pkg::EV_FINAL) begin
          out_kind_next = 1'b1;
          out_last_next = 1'b1;
          busy_next     = 1'b0;
        end
      end else if (word_in.valid) begin
        // leading clock pulse with data low
        busy_next      = 1'b1;
        cnt_next       = dbtw_pkg::EV_FIRST;
        shreg_next     = word_in.word;
        out_valid_next = 1'b1;
        out_kind_next  = 1'b0;
        out_bit_next   = 1'b0;
        out_last_next  = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  assign pin.valid    = out_valid;
  assign pin.pin_kind = out_kind;
  assign pin.data_bit = out_bit;
  assign pin.last     = out_last;

endmodule

// ----- rtl/core/dds_band_tuning_word_loader_core.sv -----
// dds_band_tuning_word_loader_core: band state, tuning word divider and serial pin frame
// depends on dbtw_pkg, dbtw_if, dbtw_divider and dbtw_serializer
//
// usage:
//   cmd is a valid/ready command channel (command, offset, band_select); pin is a
//   valid/ready channel of pin events (pin_kind, data_bit, last)
//   commands 0 to 4 update the band state and each yields one 43-event frame:
//   clock, load, 32 word bits lsb first, 8 zero clocks, final load with last set
//   commands 5 to 7 are taken and dropped with no frame and no state change
//   the first pin request of a frame follows the taken command through the
//   pending register, the divider steps and the serializer output register;
//   the frame then runs one event per cycle while the receiver is ready
//   a new command is taken once the divider has handed its word on; the
//   divider runs for the next command while the current frame is sent
//   reset: bases return to their start values, band 0, offset 0, both channels
//   empty
//   receiver stall: the pin request holds; a finished word waits in the divider
//   and cmd.ready stays low until the divider is free again
module dds_band_tuning_word_loader_core (
  input  logic       clk,
  input  logic       rst,
  dbtw_cmd_if.sink   cmd,
  dbtw_pin_if.source pin
);

  dbtw_pkg::band_t     band_index, band_index_next;
  dbtw_pkg::offset_t   offset_value, offset_value_next;
  dbtw_pkg::freq_t     base_frequency [dbtw_pkg::NUM_BANDS];
  dbtw_pkg::freq_t     base_frequency_next [dbtw_pkg::NUM_BANDS];
  logic                pending, pending_next;
  logic                accept;
  logic                div_idle;
  dbtw_pkg::div_start_t start_req;
  dbtw_pkg::word_req_t  word_req;
  logic                word_take;

  assign cmd.ready = !pending && div_idle;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_index   <= '0;
      offset_value <= '0;
      pending      <= 1'b0;
      for (int i = 0; i < dbtw_pkg::NUM_BANDS; i++) begin
        base_frequency[i] <= dbtw_pkg::base_reset(i);
      end
    end else begin
      band_index     <= band_index_next;
      offset_value   <= offset_value_next;
      pending        <= pending_next;
      base_frequency <= base_frequency_next;
    end
  end

  always_comb begin
    band_index_next     = band_index;
    offset_value_next   = offset_value;
    base_frequency_next = base_frequency;
    pending_next        = 1'b0;
    if (accept) begin
      pending_next = 1'b1;
      unique case (cmd.command)
        dbtw_pkg::CMD_SET_OFFSET: begin
          offset_value_next = cmd.offset;
        end
        dbtw_pkg::CMD_NEXT_BAND: begin
          band_index_next = (band_index == dbtw_pkg::LAST_BAND) ? '0 :
                            band_index + dbtw_pkg::band_t'(1);
        end
        dbtw_pkg::CMD_RAISE_BASE: begin
          base_frequency_next[band_index] = base_frequency[band_index] +
                                            dbtw_pkg::freq_t'(1);
        end
        dbtw_pkg::CMD_LOWER_BASE: begin
          base_frequency_next[band_index] = base_frequency[band_index] -
                                            dbtw_pkg::freq_t'(1);
        end
        dbtw_pkg::CMD_SELECT: begin
          if (int'(cmd.band_select) < dbtw_pkg::NUM_BANDS) begin
            band_index_next = dbtw_pkg::band_t'(cmd.band_select);
          end
        end
        default: begin
          pending_next = 1'b0;
        end
      endcase
    end
  end

  // frequency from the updated state, in the cycle after the command is taken
  assign start_req.valid = pending;
  assign start_req.zero  = (offset_value > dbtw_pkg::OFF_LIMIT);
  assign start_req.freq  = base_frequency[band_index] +
                           {{(dbtw_pkg::FREQ_W - dbtw_pkg::OFFSET_W)
                             {offset_value[dbtw_pkg::OFFSET_W-1]}}, offset_value};

  dbtw_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start_req (start_req),
    .idle      (div_idle),
    .word_out  (word_req),
    .word_take (word_take)
  );

  dbtw_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .word_in   (word_req),
    .word_take (word_take),
    .pin       (pin)
  );

endmodule
